// ===== hw/rtl/tch_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt-compensated heading package
// Shared widths, constants, pipeline record types and the single-step
// functions of the integer square root and of both CORDIC modes.
// ----------------------------------------------------------------------------
package tch_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int TAB_LEN = 24;
	localparam int N_STEP = (CORDIC_ITERATIONS < TAB_LEN) ? CORDIC_ITERATIONS : TAB_LEN;
	localparam int ISQ_N = 16;

	// Vectoring datapath, angle, rotation datapath, sine/cosine and scaled heading widths.
	localparam int VW = 48;
	localparam int AW = 20;
	localparam int RW = 34;
	localparam int CW = RW - 16;
	localparam int SW = 18;

	localparam logic signed [AW-1:0] HALF_PI = AW'(102944);
	localparam logic signed [RW-1:0] GAIN = RW'(652032875);
	localparam logic signed [21:0] DEG_SCALE = 22'sd1877469;
	localparam logic signed [SW-1:0] HEAD_LIMIT = SW'(23040);

	typedef struct packed {
		logic [31:0] v;
		logic [31:0] r;
	} isq_t;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [AW-1:0] z;
		logic zf;
	} vec_t;

	typedef struct packed {
		logic signed [RW-1:0] x;
		logic signed [RW-1:0] y;
		logic signed [AW-1:0] z;
	} rot_t;

	// Arctangent of 2^-i in 2^-16 rad, rounded to nearest.
	function automatic logic signed [AW-1:0] atan_at(int i);
		logic signed [AW-1:0] t;
		unique case (i)
			0: t = AW'(51472);
			1: t = AW'(30386);
			2: t = AW'(16055);
			3: t = AW'(8150);
			4: t = AW'(4091);
			5: t = AW'(2047);
			6: t = AW'(1024);
			7: t = AW'(512);
			8: t = AW'(256);
			9: t = AW'(128);
			10: t = AW'(64);
			11: t = AW'(32);
			12: t = AW'(16);
			13: t = AW'(8);
			14: t = AW'(4);
			15: t = AW'(2);
			16: t = AW'(1);
			default: t = '0;
		endcase
		return t;
	endfunction

	// One restoring step of the integer square root; step k tests bit 2^(30-2k).
	function automatic isq_t isq_step(isq_t a, int k);
		logic [32:0] b;
		logic [32:0] t;
		isq_t o;
		b = 33'(1) << (30 - 2 * k);
		t = {1'b0, a.r} + b;
		if ({1'b0, a.v} >= t) begin
			o.v = a.v - t[31:0];
			o.r = (a.r >> 1) + b[31:0];
		end else begin
			o.v = a.v;
			o.r = a.r >> 1;
		end
		return o;
	endfunction

	// Quadrant fold before vectoring: a negative x is turned by a quarter turn.
	function automatic vec_t vec_pre(logic signed [VW-1:0] yy, logic signed [VW-1:0] xx);
		vec_t o;
		o.zf = (yy == '0) && (xx == '0);
		o.x = xx;
		o.y = yy;
		o.z = '0;
		if (xx[VW-1]) begin
			if (!yy[VW-1]) begin
				o.x = yy;
				o.y = -xx;
				o.z = HALF_PI;
			end else begin
				o.x = -yy;
				o.y = xx;
				o.z = -HALF_PI;
			end
		end
		return o;
	endfunction

	function automatic vec_t vec_step(vec_t a, int i);
		vec_t o;
		o = a;
		if (!a.y[VW-1]) begin
			o.x = a.x + (a.y >>> i);
			o.y = a.y - (a.x >>> i);
			o.z = a.z + atan_at(i);
		end else begin
			o.x = a.x - (a.y >>> i);
			o.y = a.y + (a.x >>> i);
			o.z = a.z - atan_at(i);
		end
		return o;
	endfunction

	function automatic rot_t rot_step(rot_t a, int i);
		rot_t o;
		if (!a.z[AW-1]) begin
			o.x = a.x - (a.y >>> i);
			o.y = a.y + (a.x >>> i);
			o.z = a.z - atan_at(i);
		end else begin
			o.x = a.x + (a.y >>> i);
			o.y = a.y - (a.x >>> i);
			o.z = a.z + atan_at(i);
		end
		return o;
	endfunction

endpackage

// ===== hw/rtl/tilt_compensated_heading.sv =====
// ----------------------------------------------------------------------------
// Tilt-compensated compass heading
// Fully pipelined square roots, CORDIC arctangents and sine/cosine, and
// horizontal-plane rotation for one magnetometer sample per unstalled cycle.
// ----------------------------------------------------------------------------
// The sample channel (sample_valid, sample_stall, mag_x, mag_y, mag_z) takes
// one signed three-axis reading per transfer. The heading channel
// (heading_valid, heading_stall, heading) returns one heading per sample, in
// 1/128 degree between -180 and +180 degrees, in the order of the samples.
// The pipeline holds an input register, two stages for squares and sums,
// sixteen square-root stages, three CORDIC chains of one stage per iteration
// plus one fold or rounding stage each, a sine/cosine rounding stage, three
// multiply stages, a scaling stage and the output register. Throughput is
// one transfer per cycle unless held, as every stage holds its own item.
// When the receiver stalls with a heading waiting, the whole pipeline holds
// and sample_stall is raised in the same cycle; bubbles in the pipeline are
// not squeezed out. Reset clears every valid bit, so the pipeline starts empty.
// ----------------------------------------------------------------------------
module tilt_compensated_heading
	import tch_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic signed [15:0] mag_z,
	output logic               heading_valid,
	input  logic               heading_stall,
	output logic signed [15:0] heading
);

	// Stage numbers along the pipeline.
	localparam int ST_VPRE = 3 + ISQ_N;
	localparam int ST_RINI = ST_VPRE + N_STEP + 1;
	localparam int ST_CS = ST_RINI + N_STEP + 1;
	localparam int ST_FPRE = ST_CS + 4;
	localparam int ST_SCL = ST_FPRE + N_STEP + 1;
	localparam int ST_OUT = ST_SCL + 1;

	logic en;
	logic vld_q [0:ST_OUT];

	logic signed [15:0] mx_s [0:ST_CS];
	logic signed [15:0] my_s [0:ST_CS];
	logic signed [15:0] mz_s [0:ST_CS];

	logic [30:0] sqx_s1, sqy_s1, sqz_s1;
	logic signed [31:0] px, py, pz;

	isq_t isq_s [2][0:ISQ_N];
	vec_t vec_s [2][0:N_STEP];
	rot_t rot_s [2][0:N_STEP];
	vec_t fvec_s [0:N_STEP];

	logic signed [AW-1:0] roll_a, pitch_a;
	logic signed [RW-1:0] rcx, rcy, pcx, pcy;
	logic signed [CW-1:0] cr_sc, sr_sc, cp_sc, sp_sc;

	logic signed [33:0] xsr_sa, zsr_sa, xcp_sa, zsp_sa, ycr_sa;
	logic signed [CW-1:0] cp_sa, sp_sa;
	logic signed [51:0] q1_full, q2_full;
	logic signed [VW-1:0] q1_sb, q2_sb, x2_sb, ycr_sb;
	logic signed [VW-1:0] x2_sc, y2_sc;

	logic signed [AW-1:0] fa;
	logic signed [41:0] hm;
	logic signed [SW-1:0] h_sd;
	logic signed [15:0] heading_q;

	// The pipeline moves unless a finished heading is held by the receiver.
	assign en = !(vld_q[ST_OUT] && heading_stall);
	assign sample_stall = !en;
	assign heading_valid = vld_q[ST_OUT];
	assign heading = heading_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= sample_valid;
		end
	end

	genvar k, l;
	generate
		for (k = 1; k <= ST_OUT; k++) begin : g_vld
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[k] <= 1'b0;
				end else if (en) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	endgenerate

	// Input register and the delay line that keeps the raw axes beside their item.
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s[0] <= mag_x;
			my_s[0] <= mag_y;
			mz_s[0] <= mag_z;
		end
	end

	generate
		for (k = 1; k <= ST_CS; k++) begin : g_dly
			always_ff @(posedge clk) begin
				if (en) begin
					mx_s[k] <= mx_s[k-1];
					my_s[k] <= my_s[k-1];
					mz_s[k] <= mz_s[k-1];
				end
			end
		end
	endgenerate

	// Squares, then the two sums under the roots.
	always_comb begin
		px = mx_s[0] * mx_s[0];
		py = my_s[0] * my_s[0];
		pz = mz_s[0] * mz_s[0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= px[30:0];
			sqy_s1 <= py[30:0];
			sqz_s1 <= pz[30:0];
			isq_s[0][0].v <= {1'b0, sqx_s1} + {1'b0, sqz_s1};
			isq_s[0][0].r <= '0;
			isq_s[1][0].v <= {1'b0, sqy_s1} + {1'b0, sqz_s1};
			isq_s[1][0].r <= '0;
		end
	end

	// Lane 0 carries the roll path, lane 1 the pitch path.
	generate
		for (l = 0; l < 2; l++) begin : g_lane
			for (k = 1; k <= ISQ_N; k++) begin : g_isq
				always_ff @(posedge clk) begin
					if (en) begin
						isq_s[l][k] <= isq_step(isq_s[l][k-1], k - 1);
					end
				end
			end
			for (k = 1; k <= N_STEP; k++) begin : g_cordic
				always_ff @(posedge clk) begin
					if (en) begin
						vec_s[l][k] <= vec_step(vec_s[l][k-1], k - 1);
						rot_s[l][k] <= rot_step(rot_s[l][k-1], k - 1);
					end
				end
			end
		end
	endgenerate

	// Roll is atan2(y, root of x and z); pitch is atan2(x, root of y and z).
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s[0][0] <= vec_pre({{(VW-32){my_s[ST_VPRE-1][15]}}, my_s[ST_VPRE-1], 16'b0},
				{{(VW-32){1'b0}}, isq_s[0][ISQ_N].r[15:0], 16'b0});
			vec_s[1][0] <= vec_pre({{(VW-32){mx_s[ST_VPRE-1][15]}}, mx_s[ST_VPRE-1], 16'b0},
				{{(VW-32){1'b0}}, isq_s[1][ISQ_N].r[15:0], 16'b0});
		end
	end

	// Round each angle to Q2.14 and bring it back to 2^-16 rad for rotation.
	always_comb begin
		roll_a = vec_s[0][N_STEP].z + AW'(2);
		roll_a[1:0] = 2'b00;
		if (vec_s[0][N_STEP].zf) begin
			roll_a = '0;
		end
		pitch_a = vec_s[1][N_STEP].z + AW'(2);
		pitch_a[1:0] = 2'b00;
		if (vec_s[1][N_STEP].zf) begin
			pitch_a = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s[0][0].x <= GAIN;
			rot_s[0][0].y <= '0;
			rot_s[0][0].z <= roll_a;
			rot_s[1][0].x <= GAIN;
			rot_s[1][0].y <= '0;
			rot_s[1][0].z <= -pitch_a;
		end
	end

	// Sine and cosine rounded to Q1.14.
	always_comb begin
		rcx = rot_s[0][N_STEP].x + RW'(32768);
		rcy = rot_s[0][N_STEP].y + RW'(32768);
		pcx = rot_s[1][N_STEP].x + RW'(32768);
		pcy = rot_s[1][N_STEP].y + RW'(32768);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_sc <= rcx[RW-1:16];
			sr_sc <= rcy[RW-1:16];
			cp_sc <= pcx[RW-1:16];
			sp_sc <= pcy[RW-1:16];
		end
	end

	// First products of the rotation into the horizontal plane.
	always_ff @(posedge clk) begin
		if (en) begin
			xsr_sa <= mx_s[ST_CS] * sr_sc;
			zsr_sa <= mz_s[ST_CS] * sr_sc;
			xcp_sa <= mx_s[ST_CS] * cp_sc;
			zsp_sa <= mz_s[ST_CS] * sp_sc;
			ycr_sa <= my_s[ST_CS] * cr_sc;
			cp_sa <= cp_sc;
			sp_sa <= sp_sc;
		end
	end

	always_comb begin
		q1_full = xsr_sa * sp_sa;
		q2_full = zsr_sa * cp_sa;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q1_sb <= q1_full[VW-1:0];
			q2_sb <= q2_full[VW-1:0];
			x2_sb <= (VW'(xcp_sa) + VW'(zsp_sa)) <<< 14;
			ycr_sb <= VW'(ycr_sa) <<< 14;
			x2_sc <= x2_sb;
			y2_sc <= q1_sb + ycr_sb - q2_sb;
		end
	end

	// Heading is atan2(x2, y2).
	always_ff @(posedge clk) begin
		if (en) begin
			fvec_s[0] <= vec_pre(x2_sc, y2_sc);
		end
	end

	generate
		for (k = 1; k <= N_STEP; k++) begin : g_fin
			always_ff @(posedge clk) begin
				if (en) begin
					fvec_s[k] <= vec_step(fvec_s[k-1], k - 1);
				end
			end
		end
	endgenerate

	// Radians to 1/128 degree, rounded, then clamped to half a turn.
	always_comb begin
		fa = fvec_s[N_STEP].zf ? '0 : fvec_s[N_STEP].z;
		hm = fa * DEG_SCALE + 42'sd8388608;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_sd <= hm[41:24];
			if (h_sd > HEAD_LIMIT) begin
				heading_q <= HEAD_LIMIT[15:0];
			end else if (h_sd < -HEAD_LIMIT) begin
				heading_q <= 16'(-HEAD_LIMIT);
			end else begin
				heading_q <= h_sd[15:0];
			end
		end
	end

endmodule

// ===== tb/tilt_compensated_heading_tb.sv =====
// ----------------------------------------------------------------------------
// Tilt-compensated heading testbench
// Sends directed and random magnetometer samples through the pipeline while
// both channels idle at random, and checks every heading against an
// independent fixed-point model of the square roots, CORDIC stages and scaling.
// ----------------------------------------------------------------------------
module tilt_compensated_heading_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tch_pkg::*;

	localparam int RANDOM_SAMPLES = 1825;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 120;

	localparam longint ARC_TAB [24] = '{
		51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2,
		1, 0, 0, 0, 0, 0, 0, 0
	};
	localparam longint QUARTER_TURN = 102944;
	localparam longint START_GAIN = 652032875;
	localparam longint DEGREE_FACTOR = 1877469;
	localparam longint HEADING_CLAMP = 23040;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} sample_t;

	logic               clk;
	logic               arst_n;
	logic               sample_valid;
	logic               sample_stall;
	logic signed [15:0] mag_x;
	logic signed [15:0] mag_y;
	logic signed [15:0] mag_z;
	logic               heading_valid;
	logic               heading_stall;
	logic signed [15:0] heading;

	sample_t            samples_to_send [$];
	logic signed [15:0] headings_due [$];
	int                 errors = 0;
	int                 samples_sent = 0;
	int                 headings_seen = 0;
	int                 cycle_count = 0;
	logic               stimulus_done = 1'b0;

	tilt_compensated_heading dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.mag_x         (mag_x),
		.mag_y         (mag_y),
		.mag_z         (mag_z),
		.heading_valid (heading_valid),
		.heading_stall (heading_stall),
		.heading       (heading)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Floor square root of a 32-bit value, one result bit per pass.
	function automatic longint floor_root(logic [31:0] v);
		logic [31:0] rem;
		logic [31:0] res;
		logic [31:0] b;
		rem = v;
		res = '0;
		b = 32'h4000_0000;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	// CORDIC vectoring: the angle of (xx, yy) in 2^-16 rad. A negative xx is
	// first folded by a quarter turn, and the zero vector gives angle zero.
	function automatic longint vector_angle(longint yy, longint xx);
		longint ang;
		longint t;
		longint nx;
		longint ny;
		ang = 0;
		if (yy == 0 && xx == 0)
			return 0;
		if (xx < 0) begin
			t = xx;
			if (yy >= 0) begin
				xx = yy;
				yy = -t;
				ang = QUARTER_TURN;
			end else begin
				xx = -yy;
				yy = t;
				ang = -QUARTER_TURN;
			end
		end
		for (int i = 0; i < N_STEP; i++) begin
			if (yy >= 0) begin
				nx = xx + (yy >>> i);
				ny = yy - (xx >>> i);
				ang = ang + ARC_TAB[i];
			end else begin
				nx = xx - (yy >>> i);
				ny = yy + (xx >>> i);
				ang = ang - ARC_TAB[i];
			end
			xx = nx;
			yy = ny;
		end
		return ang;
	endfunction

	// CORDIC rotation of the gain-corrected unit vector by a Q2.14 angle,
	// giving cosine and sine in Q1.14.
	function automatic void rotate_unit(input longint ang_q14, output longint c,
		output longint s);
		longint rx;
		longint ry;
		longint rz;
		longint nx;
		longint ny;
		rx = START_GAIN;
		ry = 0;
		rz = ang_q14 * 4;
		for (int i = 0; i < N_STEP; i++) begin
			if (rz >= 0) begin
				nx = rx - (ry >>> i);
				ny = ry + (rx >>> i);
				rz = rz - ARC_TAB[i];
			end else begin
				nx = rx + (ry >>> i);
				ny = ry - (rx >>> i);
				rz = rz + ARC_TAB[i];
			end
			rx = nx;
			ry = ny;
		end
		c = (rx + 32768) >>> 16;
		s = (ry + 32768) >>> 16;
	endfunction

	// Full heading computation for one sample, in 1/128 degree.
	function automatic logic signed [15:0] compass_heading(sample_t smp);
		longint x;
		longint y;
		longint z;
		longint roll_root;
		longint pitch_root;
		longint roll;
		longint pitch;
		longint cos_r;
		longint sin_r;
		longint cos_p;
		longint sin_p;
		longint hx;
		longint hy;
		longint h;
		x = smp.x;
		y = smp.y;
		z = smp.z;
		roll_root = floor_root(32'(x * x + z * z));
		pitch_root = floor_root(32'(y * y + z * z));
		roll = (vector_angle(y * 65536, roll_root * 65536) + 2) >>> 2;
		pitch = (vector_angle(x * 65536, pitch_root * 65536) + 2) >>> 2;
		rotate_unit(roll, cos_r, sin_r);
		rotate_unit(-pitch, cos_p, sin_p);
		// Project the field onto the horizontal plane, exactly in Q28.
		hx = (x * cos_p + z * sin_p) * 16384;
		hy = x * sin_r * sin_p + y * cos_r * 16384 - z * sin_r * cos_p;
		h = (vector_angle(hx, hy) * DEGREE_FACTOR + (longint'(1) << 23)) >>> 24;
		if (h > HEADING_CLAMP)
			h = HEADING_CLAMP;
		if (h < -HEADING_CLAMP)
			h = -HEADING_CLAMP;
		return 16'(h);
	endfunction

	function automatic void queue_sample(int x, int y, int z);
		sample_t s;
		s.x = 16'(x);
		s.y = 16'(y);
		s.z = 16'(z);
		samples_to_send.push_back(s);
	endfunction

	function automatic int any_value();
		return int'($signed(16'($urandom)));
	endfunction

	// Stimulus: directed corners first, then a random mix.
	initial begin
		int kind;
		int lim;
		// All-zero sample gives heading zero.
		queue_sample(0, 0, 0);
		// Extremes of every field.
		queue_sample(-32768, -32768, -32768);
		queue_sample(32767, 32767, 32767);
		queue_sample(-32768, 32767, -32768);
		queue_sample(32767, -32768, 32767);
		queue_sample(-32768, 0, 0);
		queue_sample(32767, 0, 0);
		queue_sample(0, -32768, 0);
		queue_sample(0, 32767, 0);
		queue_sample(0, 0, -32768);
		queue_sample(0, 0, 32767);
		// Single negative axes with the other fields zero, then further samples
		// of mixed sign and magnitude.
		queue_sample(-1, 0, 0);
		queue_sample(0, -1, 0);
		queue_sample(0, 0, -1);
		queue_sample(1, 1, 1);
		queue_sample(-1, -1, -1);
		queue_sample(1000, -1000, 0);
		queue_sample(-1000, -1000, 0);
		queue_sample(-1000, 1000, 500);
		queue_sample(-200, -1, 3000);
		queue_sample(-200, 1, 3000);
		queue_sample(0, 100, -30000);
		queue_sample(23170, 23170, 0);
		queue_sample(-23170, -23170, 23170);
		for (int n = 0; n < RANDOM_SAMPLES; n++) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				queue_sample(any_value(), any_value(), any_value());
			end else if (kind < 82) begin
				lim = $urandom_range(1, 300);
				queue_sample($urandom_range(0, 2 * lim) - lim,
					$urandom_range(0, 2 * lim) - lim,
					$urandom_range(0, 2 * lim) - lim);
			end else if (kind < 94) begin
				// One or two axes at zero, to hit the fold and zero operands.
				case ($urandom_range(0, 5))
					0: queue_sample(0, any_value(), any_value());
					1: queue_sample(any_value(), 0, any_value());
					2: queue_sample(any_value(), any_value(), 0);
					3: queue_sample(any_value(), 0, 0);
					4: queue_sample(0, any_value(), 0);
					default: queue_sample(0, 0, any_value());
				endcase
			end else begin
				queue_sample($urandom_range(0, 1) ? 32767 : -32768,
					$urandom_range(0, 1) ? 32767 : -32768, any_value());
			end
		end
		stimulus_done = 1'b1;
	end

	// Reset and the closing sequence.
	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (stimulus_done);
		while (samples_to_send.size() != 0 || sample_valid || headings_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d samples (%0d directed corners) and checked %0d headings.",
			samples_sent, 24, headings_seen);
		$display("Both channels idled and stalled at random throughout; %0d errors.", errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Sample driver: bursts of random length separated by random gaps. A
	// transfer completes at an edge with valid high and stall low; only then
	// is the next sample presented, so a stalled payload stays put.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		sample_t s;
		logic    free;
		if (!arst_n) begin
			sample_valid <= 1'b0;
			mag_x <= '0;
			mag_y <= '0;
			mag_z <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			free = !sample_valid;
			if (sample_valid && !sample_stall) begin
				headings_due.push_back(compass_heading('{mag_x, mag_y, mag_z}));
				samples_sent++;
				free = 1'b1;
			end
			if (free) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 60);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
				if (gap_left > 0) begin
					gap_left--;
					sample_valid <= 1'b0;
				end else if (samples_to_send.size() != 0) begin
					s = samples_to_send.pop_front();
					burst_left--;
					sample_valid <= 1'b1;
					mag_x <= s.x;
					mag_y <= s.y;
					mag_z <= s.z;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Heading stall pattern: long clean stretches, light random stalls,
	// heavy random stalls and occasional long holds, switching every so often.
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_stall <= 1'b0;
			stall_mode = 0;
			mode_left = 0;
			hold_left = 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			case (stall_mode)
				0: heading_stall <= 1'b0;
				1: heading_stall <= ($urandom_range(0, 9) < 2);
				2: heading_stall <= ($urandom_range(0, 9) < 7);
				default: begin
					if (hold_left == 0)
						hold_left = $urandom_range(1, 40);
					hold_left--;
					heading_stall <= (hold_left > 10);
				end
			endcase
		end
	end

	// Heading monitor: each transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n && heading_valid && !heading_stall) begin
			headings_seen++;
			if (headings_due.size() == 0) begin
				$error("heading: unexpected transfer, actual %0d", heading);
				errors++;
			end else begin
				want = headings_due.pop_front();
				if (heading !== want) begin
					$error("heading: expected %0d, actual %0d", want, heading);
					errors++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d headings outstanding.",
				cycle_count, headings_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
hw/rtl/tch_pkg.sv
hw/rtl/tilt_compensated_heading.sv
tb/tilt_compensated_heading_tb.sv
